// ===== src/sorted_byte_list_macros.svh =====
// Assertion macros used by the sorted byte list controller.
`ifndef SORTED_BYTE_LIST_MACROS_SVH
`define SORTED_BYTE_LIST_MACROS_SVH

`ifndef ASSERT_OFF
`define SBL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sorted_byte_list assertion failed");
`define SBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_byte_list assertion failed");
`else
`define SBL_ASSERT(label, prop)
`define SBL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/sbl_pkg.sv =====
// Shared types and constants of the sorted byte list.
package sbl_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 8;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

  typedef struct packed {
    logic load_val;
    logic insert;
    logic remove_step;
    logic dump_start;
    logic dump_step;
    logic emit_drop;
    logic emit_empty;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic match_any;
    logic dump_last;
  } status_t;

endpackage

// ===== src/sbl_if.sv =====
// Request and response channel interfaces of the sorted byte list.
interface sbl_req_if;
  import sbl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface sbl_rsp_if;
  import sbl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  entry;
  logic                       last;
  logic                       empty_res;
  logic                       dropped;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, entry, last, empty_res, dropped, count, input ready);
  modport sink (input valid, entry, last, empty_res, dropped, count, output ready);
endinterface

// ===== src/sorted_byte_list.sv =====
// Top level of the sorted byte list: bounded ascending store of signed characters.
// An insert is written into the cells when accepted; a refused insert or empty dump gives its result the next cycle.
// Remove loads the value, then the chain drops one match per cycle until no match is left.
// Dump starts, then gives one result per held entry, and stalls with the output.
// Reset (synchronous, active high) empties the store; the cells themselves are not cleared.
module sorted_byte_list #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  sbl_req_if.sink    req,
  sbl_rsp_if.source  rsp
);
  import sbl_pkg::*;

  ctl_t                      ctl;
  status_t                   status;
  logic                      req_ready;
  logic                      rsp_valid;
  logic signed [VALUE_W-1:0] entry;
  logic                      last;
  logic                      empty_res;
  logic                      dropped;
  logic [COUNT_W-1:0]        count;

  sbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .action    (req.action),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .ctl       (ctl)
  );

  sbl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .status    (status),
    .value     (req.value),
    .entry     (entry),
    .last      (last),
    .empty_res (empty_res),
    .dropped   (dropped),
    .count     (count)
  );

  assign req.ready     = req_ready;
  assign rsp.valid     = rsp_valid;
  assign rsp.entry     = entry;
  assign rsp.last      = last;
  assign rsp.empty_res = empty_res;
  assign rsp.dropped   = dropped;
  assign rsp.count     = count;

endmodule

// ===== src/sbl_datapath.sv =====
// Cell chain holding the sorted entries, fill count, dump index and result register.
module sbl_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sbl_pkg::ctl_t                 ctl,
  output sbl_pkg::status_t              status,
  input  logic signed [7:0]             value,
  output logic signed [7:0]             entry,
  output logic                          last,
  output logic                          empty_res,
  output logic                          dropped,
  output logic [4:0]                    count
);
  import sbl_pkg::*;

  localparam int FW = $clog2(CAPACITY + 1);

  logic signed [VALUE_W-1:0] cells      [CAPACITY];
  logic signed [VALUE_W-1:0] cells_next [CAPACITY];
  logic signed [VALUE_W-1:0] val;
  logic [FW-1:0]             fill, fill_next;
  logic [FW-1:0]             idx, idx_next;
  logic [CAPACITY-1:0]       gt, match, low, above;
  logic [31:0]               fill_wide;

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      gt[k]    = (FW'(k) >= fill) || (cells[k] >= value);
      match[k] = (FW'(k) < fill) && (cells[k] == val);
    end
    low   = match & (~match + CAPACITY'(1));
    above = ~(low - CAPACITY'(1));
  end

  assign status.full      = (fill == FW'(CAPACITY));
  assign status.empty     = (fill == '0);
  assign status.match_any = |match;
  assign status.dump_last = ((idx + FW'(1)) == fill);
  assign fill_wide        = 32'(fill);

  always_comb begin
    cells_next = cells;
    fill_next  = fill;
    idx_next   = idx;
    if (ctl.insert) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (gt[k]) begin
          if (k == 0) begin
            cells_next[k] = value;
          end else begin
            cells_next[k] = gt[k-1] ? cells[k-1] : value;
          end
        end
      end
      fill_next = fill + FW'(1);
    end
    if (ctl.remove_step) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        if (above[k]) begin
          cells_next[k] = cells[k+1];
        end
      end
      fill_next = fill - FW'(1);
    end
    if (ctl.dump_start) begin
      idx_next = '0;
    end
    if (ctl.dump_step) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (k == CAPACITY - 1) begin
          cells_next[k] = cells[0];
        end else begin
          cells_next[k] = (FW'(k + 1) == fill) ? cells[0] : cells[k+1];
        end
      end
      idx_next = idx + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    cells <= cells_next;
    if (ctl.load_val) begin
      val <= value;
    end
    if (ctl.emit_drop) begin
      entry     <= value;
      last      <= 1'b1;
      empty_res <= 1'b0;
      dropped   <= 1'b1;
      count     <= fill_wide[COUNT_W-1:0];
    end else if (ctl.emit_empty) begin
      entry     <= '0;
      last      <= 1'b1;
      empty_res <= 1'b1;
      dropped   <= 1'b0;
      count     <= fill_wide[COUNT_W-1:0];
    end else if (ctl.dump_step) begin
      entry     <= cells[0];
      last      <= status.dump_last;
      empty_res <= 1'b0;
      dropped   <= 1'b0;
      count     <= fill_wide[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      idx  <= '0;
    end else begin
      fill <= fill_next;
      idx  <= idx_next;
    end
  end

endmodule

// ===== src/sbl_ctrl.sv =====
// Controller state machine sequencing insert, remove and dump transactions.
`include "sorted_byte_list_macros.svh"

module sbl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [1:0]           action,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  sbl_pkg::status_t     status,
  output sbl_pkg::ctl_t        ctl
);
  import sbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REMOVE = 3'b010,
    S_DUMP   = 3'b100
  } state_t;

  state_t state, state_next;
  logic   slot_free;
  logic   accept;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_INSERT: begin
              if (status.full) begin
                ctl.emit_drop = 1'b1;
              end else begin
                ctl.insert = 1'b1;
              end
            end
            ACT_REMOVE: begin
              ctl.load_val = 1'b1;
              state_next   = S_REMOVE;
            end
            ACT_DUMP: begin
              if (status.empty) begin
                ctl.emit_empty = 1'b1;
              end else begin
                ctl.dump_start = 1'b1;
                state_next     = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REMOVE: begin
        if (status.match_any) begin
          ctl.remove_step = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          ctl.dump_step = 1'b1;
          if (status.dump_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit_drop || ctl.emit_empty || ctl.dump_step) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `SBL_ASSERT(a_ready_only_idle, req_ready |-> state == S_IDLE)
  `SBL_ASSERT(a_no_insert_when_full, ctl.insert |-> !status.full)
  `SBL_ASSERT_NEXT(a_remove_done, state == S_REMOVE && !status.match_any, state == S_IDLE)
  `SBL_ASSERT_NEXT(a_dump_end, ctl.dump_step && status.dump_last, state == S_IDLE && rsp_valid)

endmodule
